// ===== rtl/pps_pkg.sv =====
`default_nettype none
package pps_pkg;

	localparam int SLOTS  = 16;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int TIME_W = 16;
	localparam int ID_W   = 16;
	localparam int PRIO_W = 8;

	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_TICK  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIND,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [ID_W-1:0]   ident;
		logic [TIME_W-1:0] arrival;
		logic [TIME_W-1:0] total;
		logic [TIME_W-1:0] remaining;
		logic [PRIO_W-1:0] prio;
	} slot_t;

	localparam int SLOT_BITS = $bits(slot_t);

	typedef struct packed {
		logic clear;
		logic check;
	} pick_ctl_t;

	typedef struct packed {
		logic              ran_valid;
		logic [ID_W-1:0]   ran_id;
		logic              done_res;
		logic [TIME_W-1:0] wait_ticks;
		logic [TIME_W-1:0] turnaround_ticks;
		logic              table_full;
	} res_t;

endpackage
`default_nettype wire

// ===== rtl/pps_ram.sv =====
`default_nettype none
module pps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/pps_pick.sv =====
`default_nettype none
module pps_pick (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire pps_pkg::pick_ctl_t               ctl,
	input  wire logic [pps_pkg::SLOT_W-1:0]       slot,
	input  wire logic                             used,
	input  wire pps_pkg::slot_t                   entry,
	input  wire logic [pps_pkg::TIME_W-1:0]       now,
	output logic                                  found,
	output logic [pps_pkg::SLOT_W-1:0]            best_slot,
	output pps_pkg::slot_t                        best
);

	logic found_q;
	logic [pps_pkg::SLOT_W-1:0] best_slot_q;
	pps_pkg::slot_t best_q;
	logic ready_task;
	logic better;
	logic take;

	always_comb begin
		ready_task = used && (entry.remaining != '0) && (entry.arrival <= now);
		// strict compares keep the lower slot on a full tie
		better = !found_q || (entry.prio < best_q.prio) ||
			((entry.prio == best_q.prio) && (entry.arrival < best_q.arrival));
		take = ctl.check && ready_task && better;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.clear) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_slot_q <= slot;
			best_q      <= entry;
		end
	end

	assign found     = found_q;
	assign best_slot = best_slot_q;
	assign best      = best_q;

endmodule
`default_nettype wire

// ===== rtl/preemptive_priority_scheduler.sv =====
// Preemptive priority scheduler over a table of SLOTS process slots. Each input beat is a
// command: load a process into the lowest free slot, advance one tick, or clear the table
// and the tick counter; every beat gives exactly one result beat. A tick walks the slot
// RAM one slot per cycle through its single read port and keeps the best ready task in a
// compare unit. A load scans the used bits one slot per cycle. One beat is in work at a
// time; a finished result waits in the output register while the next beat is accepted.
`default_nettype none
module preemptive_priority_scheduler (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [1:0]                    cmd,
	input  wire logic [pps_pkg::ID_W-1:0]      proc_id,
	input  wire logic [pps_pkg::TIME_W-1:0]    arrival,
	input  wire logic [pps_pkg::TIME_W-1:0]    burst,
	input  wire logic [pps_pkg::PRIO_W-1:0]    prio,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               ran_valid,
	output logic [pps_pkg::ID_W-1:0]           ran_id,
	output logic                               done_res,
	output logic [pps_pkg::TIME_W-1:0]         wait_ticks,
	output logic [pps_pkg::TIME_W-1:0]         turnaround_ticks,
	output logic                               table_full
);

	localparam logic [pps_pkg::SLOT_W-1:0] LAST_SLOT = pps_pkg::SLOT_W'(pps_pkg::SLOTS - 1);

	pps_pkg::state_t state_q, state_d;

	pps_pkg::slot_t              load_q;
	logic [pps_pkg::SLOT_W-1:0]  idx_q;
	logic [pps_pkg::SLOTS-1:0]   used_q;
	logic [pps_pkg::TIME_W-1:0]  now_q;
	logic                        chk_s1;
	logic [pps_pkg::SLOT_W-1:0]  slot_s1;
	logic                        used_s1;
	pps_pkg::res_t               res_q;
	pps_pkg::res_t               out_q;
	logic                        out_valid_q;

	logic                        ram_we;
	logic [pps_pkg::SLOT_W-1:0]  ram_waddr;
	pps_pkg::slot_t              ram_wdata;
	pps_pkg::slot_t              ram_rdata;

	pps_pkg::pick_ctl_t          pick_ctl;
	logic                        found;
	logic [pps_pkg::SLOT_W-1:0]  best_slot;
	pps_pkg::slot_t              best;

	logic                        accept;
	logic                        out_free;
	logic                        last;
	logic [pps_pkg::TIME_W:0]    fin_w;
	logic [pps_pkg::TIME_W:0]    turn_w;
	logic [pps_pkg::TIME_W:0]    wait_w;
	logic [pps_pkg::TIME_W-1:0]  turn_sat;
	logic [pps_pkg::TIME_W-1:0]  wait_sat;
	logic [pps_pkg::TIME_W-1:0]  rem_dec;
	logic                        task_done;
	pps_pkg::slot_t              upd_entry;

	pps_ram #(
		.WIDTH(pps_pkg::SLOT_BITS),
		.DEPTH(pps_pkg::SLOTS)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	pps_pick u_pick (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (pick_ctl),
		.slot     (slot_s1),
		.used     (used_s1),
		.entry    (ram_rdata),
		.now      (now_q),
		.found    (found),
		.best_slot(best_slot),
		.best     (best)
	);

	// finish-time arithmetic on the chosen task
	always_comb begin
		fin_w    = {1'b0, now_q} + {{pps_pkg::TIME_W{1'b0}}, 1'b1};
		turn_w   = fin_w - {1'b0, best.arrival};
		wait_w   = turn_w - {1'b0, best.total};
		turn_sat = turn_w[pps_pkg::TIME_W] ? '1 : turn_w[pps_pkg::TIME_W-1:0];
		if (turn_w < {1'b0, best.total}) begin
			wait_sat = '0;
		end else begin
			wait_sat = wait_w[pps_pkg::TIME_W] ? '1 : wait_w[pps_pkg::TIME_W-1:0];
		end
		rem_dec   = best.remaining - {{(pps_pkg::TIME_W-1){1'b0}}, 1'b1};
		task_done = (rem_dec == '0);
		upd_entry = best;
		upd_entry.remaining = rem_dec;
	end

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign last     = (idx_q == LAST_SLOT);

	always_comb begin
		state_d        = state_q;
		in_ready       = 1'b0;
		ram_we         = 1'b0;
		ram_waddr      = idx_q;
		ram_wdata      = load_q;
		pick_ctl.clear = 1'b0;
		pick_ctl.check = chk_s1;
		unique case (state_q)
			pps_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (cmd)
						pps_pkg::CMD_LOAD: state_d = pps_pkg::ST_FIND;
						pps_pkg::CMD_TICK: begin
							state_d        = pps_pkg::ST_SCAN;
							pick_ctl.clear = 1'b1;
						end
						default: state_d = pps_pkg::ST_EMIT;
					endcase
				end
			end
			pps_pkg::ST_FIND: begin
				if (!used_q[idx_q]) begin
					ram_we  = 1'b1;
					state_d = pps_pkg::ST_EMIT;
				end else if (last) begin
					state_d = pps_pkg::ST_EMIT;
				end
			end
			pps_pkg::ST_SCAN: begin
				if (last) begin
					state_d = pps_pkg::ST_DRAIN;
				end
			end
			pps_pkg::ST_DRAIN: state_d = pps_pkg::ST_FINISH;
			pps_pkg::ST_FINISH: begin
				if (found) begin
					ram_we    = 1'b1;
					ram_waddr = best_slot;
					ram_wdata = upd_entry;
				end
				state_d = pps_pkg::ST_EMIT;
			end
			pps_pkg::ST_EMIT: begin
				if (out_free) begin
					state_d = pps_pkg::ST_IDLE;
				end
			end
			default: state_d = pps_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pps_pkg::ST_IDLE;
			idx_q       <= '0;
			used_q      <= '0;
			now_q       <= '0;
			chk_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			chk_s1  <= (state_q == pps_pkg::ST_SCAN);
			if (state_q == pps_pkg::ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				pps_pkg::ST_IDLE: begin
					if (accept) begin
						idx_q <= '0;
						if (cmd == pps_pkg::CMD_CLEAR) begin
							used_q <= '0;
							now_q  <= '0;
						end
					end
				end
				pps_pkg::ST_FIND: begin
					if (!used_q[idx_q]) begin
						used_q[idx_q] <= 1'b1;
					end else if (!last) begin
						idx_q <= idx_q + {{(pps_pkg::SLOT_W-1){1'b0}}, 1'b1};
					end
				end
				pps_pkg::ST_SCAN: idx_q <= idx_q + {{(pps_pkg::SLOT_W-1){1'b0}}, 1'b1};
				pps_pkg::ST_DRAIN: ;
				pps_pkg::ST_FINISH: begin
					now_q <= now_q + {{(pps_pkg::TIME_W-1){1'b0}}, 1'b1};
					if (found && task_done) begin
						used_q[best_slot] <= 1'b0;
					end
				end
				pps_pkg::ST_EMIT: ;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		slot_s1 <= idx_q;
		used_s1 <= used_q[idx_q];
		if (accept) begin
			load_q.ident      <= proc_id;
			load_q.arrival    <= arrival;
			load_q.total      <= burst;
			load_q.remaining  <= burst;
			load_q.prio       <= prio;
			res_q             <= '0;
		end
		if (state_q == pps_pkg::ST_FIND && used_q[idx_q] && last) begin
			res_q.table_full <= 1'b1;
		end
		if (state_q == pps_pkg::ST_FINISH && found) begin
			res_q.ran_valid <= 1'b1;
			res_q.ran_id    <= best.ident;
			if (task_done) begin
				res_q.done_res         <= 1'b1;
				res_q.wait_ticks       <= wait_sat;
				res_q.turnaround_ticks <= turn_sat;
			end
		end
		if (state_q == pps_pkg::ST_EMIT && out_free) begin
			out_q <= res_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign ran_valid        = out_q.ran_valid;
	assign ran_id           = out_q.ran_id;
	assign done_res         = out_q.done_res;
	assign wait_ticks       = out_q.wait_ticks;
	assign turnaround_ticks = out_q.turnaround_ticks;
	assign table_full       = out_q.table_full;

	a_done_ran: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> ran_valid)
		else $error("finished task reported without running");

	a_full_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && table_full |-> !ran_valid && !done_res)
		else $error("rejected load carries tick fields");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd == pps_pkg::CMD_CLEAR |=> now_q == '0 && used_q == '0)
		else $error("clear left state behind");

	a_scan_drained: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !chk_s1)
		else $error("compare pipeline busy while accepting a beat");

endmodule
`default_nettype wire
